// File: rtl/calendar_clock_with_runtime_hours_unit_assert.svh
// Assertion macros for the calendar clock with runtime hour meters.
// Included by the top level; needs nothing else.
`ifndef CALENDAR_CLOCK_WITH_RUNTIME_HOURS_UNIT_ASSERT_SVH
`define CALENDAR_CLOCK_WITH_RUNTIME_HOURS_UNIT_ASSERT_SVH

// Check that cons holds in the same cycle as ante.
`define CCRH_ASSERT_IMPLY(name, clk, rst_n, ante, cons) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("same-cycle implication failed");

// Check that cons holds in the cycle after ante.
`define CCRH_ASSERT_NEXT(name, clk, rst_n, ante, cons) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("next-cycle implication failed");

`endif

// File: rtl/ccrh_pkg.sv
// Shared types, codes and constants of the calendar clock with hour meters.
// No dependencies; every RTL module imports it.
package ccrh_pkg;

  // Function codes of an input beat
  typedef enum logic [1:0] {
    FUNC_TICK     = 2'd0,
    FUNC_SET_TIME = 2'd1,
    FUNC_SET_DATE = 2'd2,
    FUNC_SET_YEAR = 2'd3
  } func_e;

  // Classified operation handed from the front end to the back end
  typedef enum logic [2:0] {
    OP_TICK     = 3'd0,
    OP_SET_TIME = 3'd1,
    OP_SET_DATE = 3'd2,
    OP_SET_YEAR = 3'd3,
    OP_REJECT   = 3'd4
  } op_e;

  // Configuration register indexes (paddr[3:2])
  localparam logic [1:0] REG_HEATING_EN     = 2'd0;
  localparam logic [1:0] REG_HOT_WATER_EN   = 2'd1;
  localparam logic [1:0] REG_TICKS_PER_HOUR = 2'd2;

  localparam int unsigned APB_ADDR_W = 4;
  localparam int unsigned APB_DATA_W = 32;

  localparam int unsigned ELAPSED_W = 14;
  localparam int unsigned SUB_MS_W  = 17;
  localparam logic [31:0] MAX_ELAPSED_MS = 32'd10000;
  localparam logic [SUB_MS_W-1:0] MS_PER_MINUTE = 17'd60000;

  localparam logic [15:0] TICKS_PER_HOUR_RST = 16'd36000;
  localparam logic [15:0] YEAR_LOW  = 16'd2000;
  localparam logic [15:0] YEAR_HIGH = 16'd2099;
  localparam logic [2:0]  WEEKDAY_LAST = 3'd7;
  localparam logic [4:0]  HOUR_LAST    = 5'd23;
  localparam logic [5:0]  MINUTE_LAST  = 6'd59;
  localparam logic [3:0]  MONTH_LAST   = 4'd12;

  localparam int unsigned QUEUE_DEPTH = 2;

  typedef struct packed {
    logic [1:0]  func;
    logic [31:0] now_ms;
    logic        flame_lit;
    logic [3:0]  new_weekday;
    logic [4:0]  new_hour;
    logic [5:0]  new_minute;
    logic [3:0]  new_month;
    logic [4:0]  new_day;
    logic [15:0] new_year;
  } in_beat_t;

  typedef struct packed {
    logic        accepted;
    logic [2:0]  weekday_now;
    logic [4:0]  hour_now;
    logic [5:0]  minute_now;
    logic [4:0]  day_now;
    logic [3:0]  month_now;
    logic [15:0] year_now;
    logic [31:0] burner_hours_now;
    logic [31:0] heating_pump_hours_now;
    logic [31:0] hot_water_pump_hours_now;
  } out_beat_t;

  // One classified job in the queue
  typedef struct packed {
    op_e                  op;
    logic [ELAPSED_W-1:0] elapsed_ms;
    logic                 flame_lit;
    logic [2:0]           weekday;
    logic [4:0]           hour;
    logic [5:0]           minute;
    logic [3:0]           month;
    logic [4:0]           day;
    logic [15:0]          year;
  } job_t;

  typedef struct packed {
    logic        heating_en;
    logic        hot_water_en;
    logic [15:0] ticks_per_hour;
  } cfg_t;

  // Days in a month; February gets 29 days when the year is divisible by 4
  function automatic logic [4:0] month_days(logic [3:0] month, logic [15:0] year);
    logic [4:0] days;
    case (month)
      4'd2:                      days = (year[1:0] == 2'd0) ? 5'd29 : 5'd28;
      4'd4, 4'd6, 4'd9, 4'd11:   days = 5'd30;
      default:                   days = 5'd31;
    endcase
    return days;
  endfunction

endpackage

// File: rtl/ccrh_front.sv
// Front end: accepts input beats, tracks the last timestamp and classifies
// and validates each beat into a job. Depends on ccrh_pkg.
module ccrh_front (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  input  ccrh_pkg::in_beat_t in_beat_i,
  output logic               in_stall_o,
  input  logic               q_full_i,
  output logic               push_o,
  output ccrh_pkg::job_t     job_o
);
  import ccrh_pkg::*;

  logic [31:0] last_stamp_q, last_stamp_d;
  logic [31:0] elapsed;
  logic        counted;
  logic        accept;
  logic        time_ok, date_ok, year_ok;

  // Stall while the queue has no room
  assign in_stall_o = q_full_i;
  assign accept     = in_valid_i && !q_full_i;
  assign push_o     = accept;

  // Elapsed time modulo 2^32, counted only inside the open window
  assign elapsed = in_beat_i.now_ms - last_stamp_q;
  assign counted = (elapsed != 32'd0) && (elapsed < MAX_ELAPSED_MS);

  // Validate set values
  assign time_ok = (in_beat_i.new_weekday <= 4'(WEEKDAY_LAST)) &&
                   (in_beat_i.new_hour <= HOUR_LAST) &&
                   (in_beat_i.new_minute <= MINUTE_LAST);
  assign date_ok = (in_beat_i.new_month >= 4'd1) && (in_beat_i.new_month <= MONTH_LAST) &&
                   (in_beat_i.new_day != 5'd0);
  assign year_ok = (in_beat_i.new_year >= YEAR_LOW) && (in_beat_i.new_year <= YEAR_HIGH);

  // Build the job
  always_comb begin
    job_o.elapsed_ms = counted ? elapsed[ELAPSED_W-1:0] : '0;
    job_o.flame_lit  = in_beat_i.flame_lit;
    job_o.weekday    = in_beat_i.new_weekday[2:0];
    job_o.hour       = in_beat_i.new_hour;
    job_o.minute     = in_beat_i.new_minute;
    job_o.month      = in_beat_i.new_month;
    job_o.day        = in_beat_i.new_day;
    job_o.year       = in_beat_i.new_year;
    last_stamp_d     = last_stamp_q;
    unique case (func_e'(in_beat_i.func))
      FUNC_TICK: begin
        job_o.op = OP_TICK;
        if (accept) begin
          last_stamp_d = in_beat_i.now_ms;
        end
      end
      FUNC_SET_TIME: job_o.op = time_ok ? OP_SET_TIME : OP_REJECT;
      FUNC_SET_DATE: job_o.op = date_ok ? OP_SET_DATE : OP_REJECT;
      FUNC_SET_YEAR: job_o.op = year_ok ? OP_SET_YEAR : OP_REJECT;
      default:       job_o.op = OP_REJECT;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      last_stamp_q <= '0;
    end else begin
      last_stamp_q <= last_stamp_d;
    end
  end

endmodule

// File: rtl/ccrh_queue.sv
// Short job queue between the front end and the back end.
// Depends on ccrh_pkg for the job type and depth.
module ccrh_queue (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           push_i,
  input  ccrh_pkg::job_t job_i,
  output logic           full_o,
  output logic           valid_o,
  input  logic           pop_i,
  output ccrh_pkg::job_t job_o
);
  import ccrh_pkg::*;

  localparam int unsigned PtrW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int unsigned CntW = $clog2(QUEUE_DEPTH + 1);

  job_t            slots_q [QUEUE_DEPTH];
  logic [PtrW-1:0] wr_ptr_q, wr_ptr_d;
  logic [PtrW-1:0] rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0] count_q, count_d;

  assign full_o  = (count_q == CntW'(QUEUE_DEPTH));
  assign valid_o = (count_q != '0);
  assign job_o   = slots_q[rd_ptr_q];

  // Advance pointers and count
  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (push_i) begin
      wr_ptr_d = (wr_ptr_q == PtrW'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (pop_i) begin
      rd_ptr_d = (rd_ptr_q == PtrW'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    if (push_i && !pop_i) begin
      count_d = count_q + 1'b1;
    end else if (pop_i && !push_i) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  // Store the pushed job
  always_ff @(posedge clk_i) begin
    if (push_i) begin
      slots_q[wr_ptr_q] <= job_i;
    end
  end

endmodule

// File: rtl/ccrh_back.sv
// Back end: holds the calendar and hour meters, executes one job per cycle
// unless the output stalls, and presents the result beat. Depends on ccrh_pkg.
module ccrh_back #(
  parameter int unsigned HOUR_COUNT_WIDTH = 32
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  ccrh_pkg::cfg_t      cfg_i,
  input  logic                job_valid_i,
  input  ccrh_pkg::job_t      job_i,
  output logic                job_pop_o,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output ccrh_pkg::out_beat_t out_beat_o
);
  import ccrh_pkg::*;

  localparam int unsigned NumMeters = 3;

  logic [SUB_MS_W-1:0] sub_ms_q, sub_ms_d, sub_sum;
  logic [5:0]          minute_q, minute_d;
  logic [4:0]          hour_q, hour_d;
  logic [2:0]          weekday_q, weekday_d;
  logic [4:0]          day_q, day_d;
  logic [5:0]          day_inc;
  logic [3:0]          month_q, month_d;
  logic [15:0]         year_q, year_d;
  logic                accepted_q, accepted_d;
  logic                out_valid_q, out_valid_d;
  logic                minute_roll, hour_roll, day_roll, month_roll, year_roll;
  logic                is_tick;

  logic [15:0]                 ticks_q [NumMeters];
  logic [15:0]                 ticks_d [NumMeters];
  logic [HOUR_COUNT_WIDTH-1:0] hours_q [NumMeters];
  logic [HOUR_COUNT_WIDTH-1:0] hours_d [NumMeters];
  logic [16:0]                 tick_sum [NumMeters];
  logic                        meter_en [NumMeters];

  // Take a job when the result register is free or being drained
  assign job_pop_o   = job_valid_i && (!out_valid_q || !out_stall_i);
  assign out_valid_d = job_pop_o || (out_valid_q && out_stall_i);
  assign is_tick     = (job_i.op == OP_TICK);

  // Rollover cascade for a tick
  assign sub_sum     = sub_ms_q + SUB_MS_W'(job_i.elapsed_ms);
  assign minute_roll = (sub_sum >= MS_PER_MINUTE);
  assign hour_roll   = minute_roll && (minute_q >= MINUTE_LAST);
  assign day_roll    = hour_roll && (hour_q >= HOUR_LAST);
  assign day_inc     = 6'(day_q) + 6'd1;
  assign month_roll  = day_roll && (day_inc > 6'(month_days(month_q, year_q)));
  assign year_roll   = month_roll && (month_q >= MONTH_LAST);

  // Calendar next state
  always_comb begin
    sub_ms_d   = sub_ms_q;
    minute_d   = minute_q;
    hour_d     = hour_q;
    weekday_d  = weekday_q;
    day_d      = day_q;
    month_d    = month_q;
    year_d     = year_q;
    accepted_d = 1'b1;
    unique case (job_i.op)
      OP_TICK: begin
        sub_ms_d = minute_roll ? sub_sum - MS_PER_MINUTE : sub_sum;
        if (minute_roll) begin
          minute_d = hour_roll ? 6'd0 : minute_q + 6'd1;
        end
        if (hour_roll) begin
          hour_d = day_roll ? 5'd0 : hour_q + 5'd1;
        end
        if (day_roll) begin
          weekday_d = (weekday_q >= WEEKDAY_LAST) ? 3'd1 : weekday_q + 3'd1;
          day_d     = month_roll ? 5'd1 : day_inc[4:0];
        end
        if (month_roll) begin
          month_d = year_roll ? 4'd1 : month_q + 4'd1;
        end
        if (year_roll) begin
          year_d = year_q + 16'd1;
        end
      end
      OP_SET_TIME: begin
        weekday_d = job_i.weekday;
        hour_d    = job_i.hour;
        minute_d  = job_i.minute;
      end
      OP_SET_DATE: begin
        month_d = job_i.month;
        day_d   = job_i.day;
      end
      OP_SET_YEAR: year_d = job_i.year;
      OP_REJECT:   accepted_d = 1'b0;
      default:     accepted_d = 1'b0;
    endcase
  end

  // Hour meters: count enabled ticks, add an hour at the limit
  assign meter_en[0] = job_i.flame_lit;
  assign meter_en[1] = cfg_i.heating_en;
  assign meter_en[2] = cfg_i.hot_water_en;

  always_comb begin
    for (int i = 0; i < NumMeters; i++) begin
      tick_sum[i] = {1'b0, ticks_q[i]} + 17'd1;
      ticks_d[i]  = ticks_q[i];
      hours_d[i]  = hours_q[i];
      if (is_tick && meter_en[i]) begin
        if (tick_sum[i] >= {1'b0, cfg_i.ticks_per_hour}) begin
          ticks_d[i] = '0;
          hours_d[i] = hours_q[i] + 1'b1;
        end else begin
          ticks_d[i] = tick_sum[i][15:0];
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
      accepted_q  <= 1'b0;
      sub_ms_q    <= '0;
      minute_q    <= '0;
      hour_q      <= '0;
      weekday_q   <= 3'd1;
      day_q       <= 5'd1;
      month_q     <= 4'd1;
      year_q      <= YEAR_LOW;
      for (int i = 0; i < NumMeters; i++) begin
        ticks_q[i] <= '0;
        hours_q[i] <= '0;
      end
    end else begin
      out_valid_q <= out_valid_d;
      if (job_pop_o) begin
        accepted_q <= accepted_d;
        sub_ms_q   <= sub_ms_d;
        minute_q   <= minute_d;
        hour_q     <= hour_d;
        weekday_q  <= weekday_d;
        day_q      <= day_d;
        month_q    <= month_d;
        year_q     <= year_d;
        for (int i = 0; i < NumMeters; i++) begin
          ticks_q[i] <= ticks_d[i];
          hours_q[i] <= hours_d[i];
        end
      end
    end
  end

  // Result beat straight from the state registers
  assign out_valid_o = out_valid_q;
  always_comb begin
    out_beat_o.accepted                 = accepted_q;
    out_beat_o.weekday_now              = weekday_q;
    out_beat_o.hour_now                 = hour_q;
    out_beat_o.minute_now               = minute_q;
    out_beat_o.day_now                  = day_q;
    out_beat_o.month_now                = month_q;
    out_beat_o.year_now                 = year_q;
    out_beat_o.burner_hours_now         = 32'(hours_q[0]);
    out_beat_o.heating_pump_hours_now   = 32'(hours_q[1]);
    out_beat_o.hot_water_pump_hours_now = 32'(hours_q[2]);
  end

endmodule

// File: rtl/calendar_clock_with_runtime_hours_unit.sv
// Calendar clock with runtime hour meters: one item per clock cycle unless stalled.
// An accepted item is written into the two-entry queue and then taken into the
// back end's result registers; its result beat is held until taken. The back end
// executes one job per cycle; output stalls hold it and back up the queue.
// Reset (async, active low): clock at 00:00 Monday 1/1/2000, meters and
// timestamp zero, ticks_per_hour 36000, both pump enables off.
`include "calendar_clock_with_runtime_hours_unit_assert.svh"

module calendar_clock_with_runtime_hours_unit #(
  parameter int unsigned HOUR_COUNT_WIDTH = 32
) (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 in_valid_i,
  input  ccrh_pkg::in_beat_t                   in_beat_i,
  output logic                                 in_stall_o,
  output logic                                 out_valid_o,
  input  logic                                 out_stall_i,
  output ccrh_pkg::out_beat_t                  out_beat_o,
  input  logic                                 psel,
  input  logic                                 penable,
  input  logic                                 pwrite,
  input  logic [ccrh_pkg::APB_ADDR_W-1:0]      paddr,
  input  logic [ccrh_pkg::APB_DATA_W-1:0]      pwdata,
  output logic [ccrh_pkg::APB_DATA_W-1:0]      prdata,
  output logic                                 pready
);
  import ccrh_pkg::*;

  cfg_t       cfg_q;
  logic       cfg_wr;
  logic       push;
  logic       q_full;
  logic       job_valid;
  logic       job_pop;
  job_t       job_in;
  job_t       job_out;

  // Configuration registers
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.heating_en     <= 1'b0;
      cfg_q.hot_water_en   <= 1'b0;
      cfg_q.ticks_per_hour <= TICKS_PER_HOUR_RST;
    end else if (cfg_wr) begin
      unique case (paddr[3:2])
        REG_HEATING_EN:     cfg_q.heating_en     <= pwdata[0];
        REG_HOT_WATER_EN:   cfg_q.hot_water_en   <= pwdata[0];
        REG_TICKS_PER_HOUR: cfg_q.ticks_per_hour <= pwdata[15:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[3:2])
      REG_HEATING_EN:     prdata = 32'(cfg_q.heating_en);
      REG_HOT_WATER_EN:   prdata = 32'(cfg_q.hot_water_en);
      REG_TICKS_PER_HOUR: prdata = 32'(cfg_q.ticks_per_hour);
      default:            prdata = '0;
    endcase
  end

  ccrh_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_beat_i  (in_beat_i),
    .in_stall_o (in_stall_o),
    .q_full_i   (q_full),
    .push_o     (push),
    .job_o      (job_in)
  );

  ccrh_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .job_i   (job_in),
    .full_o  (q_full),
    .valid_o (job_valid),
    .pop_i   (job_pop),
    .job_o   (job_out)
  );

  ccrh_back #(
    .HOUR_COUNT_WIDTH (HOUR_COUNT_WIDTH)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg_q),
    .job_valid_i (job_valid),
    .job_i       (job_out),
    .job_pop_o   (job_pop),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_beat_o  (out_beat_o)
  );

  // A pop only takes a queued job
  `CCRH_ASSERT_IMPLY(a_pop_has_job, clk_i, rst_ni, job_pop, job_valid)
  // A popped job always shows up as a result beat
  `CCRH_ASSERT_NEXT(a_pop_gives_beat, clk_i, rst_ni, job_pop, out_valid_o)
  // The presented clock stays within its calendar ranges
  `CCRH_ASSERT_IMPLY(a_calendar_range, clk_i, rst_ni, out_valid_o, (out_beat_o.month_now >= 4'd1) && (out_beat_o.month_now <= MONTH_LAST) && (out_beat_o.day_now != 5'd0) && (out_beat_o.hour_now <= HOUR_LAST) && (out_beat_o.minute_now <= MINUTE_LAST))

endmodule
